// File: rtl/lkms_pkg.sv
// Shared types, constants, keymap and helper functions for the layered key matrix scanner.
package lkms_pkg;

    localparam int ROWS     = 4;
    localparam int COLS     = 6;
    localparam int NUM_POS  = ROWS * COLS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLS);
    localparam int POS_W    = $clog2(NUM_POS);

    localparam int TIME_W   = 32;
    localparam int MASK_W   = 24;
    localparam int CODE_W   = 8;
    localparam int DEB_W    = 16;
    localparam int S_DATA_W = ((TIME_W + MASK_W + 7) / 8) * 8;
    localparam int TBL_DEPTH = 1 << CODE_W;

    localparam logic [DEB_W-1:0] DEB_RESET = 16'd160;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CODE_W-1:0] CODE_ALT  = 8'h82;
    localparam logic [CODE_W-1:0] CODE_GUI  = 8'h83;
    localparam logic [CODE_W-1:0] CODE_LYR  = 8'h4C;
    localparam logic [CODE_W-1:0] CODE_STAR = 8'h2A;
    localparam logic [CODE_W-1:0] CODE_X    = 8'h58;

    localparam int CHORD_ROW       = 3;
    localparam int CHORD_LEFT_COL  = 1;
    localparam int CHORD_RIGHT_COL = 2;
    localparam int ALT_ROW         = 2;
    localparam int ALT_COL         = 5;
    localparam int CHORD_A_POS     = CHORD_ROW * COLS + CHORD_LEFT_COL;
    localparam int CHORD_B_POS     = CHORD_ROW * COLS + CHORD_RIGHT_COL;
    localparam int ALT_POS         = ALT_ROW * COLS + ALT_COL;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_TAP     = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_PRESS   = 2'd1,
        EVT_RELEASE = 2'd2
    } evt_t;

    typedef enum logic [1:0] {
        LYR_BASE = 2'd0,
        LYR_ONE  = 2'd1,
        LYR_TWO  = 2'd2
    } layer_t;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [MASK_W-1:0] mask;
        layer_t            layer;
        logic              both;
        evt_t              gui_evt;
        evt_t              alt_evt;
    } cmd_t;

    localparam int KM_LAYERS = 3;
    localparam int KM_ROWS   = 4;
    localparam int KM_COLS   = 6;

    localparam logic [CODE_W-1:0] KEYMAP [KM_LAYERS][KM_ROWS][KM_COLS] = '{
        '{
            '{8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'hB2},
            '{8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27},
            '{8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h82},
            '{8'h20, 8'h4C, 8'h58, 8'h2A, 8'h2A, 8'h2A}
        },
        '{
            '{8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D},
            '{8'hD8, 8'hD9, 8'hDA, 8'hD7, 8'h2A, 8'h5C},
            '{8'h5B, 8'h5D, 8'hD2, 8'hD5, 8'hD3, 8'hD6},
            '{8'h20, 8'h4C, 8'h83, 8'h2A, 8'h2A, 8'h2A}
        },
        '{
            '{8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7},
            '{8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD},
            '{8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A},
            '{8'h20, 8'h4C, 8'h58, 8'h2A, 8'h2A, 8'h2A}
        }
    };

    // positions outside the 4x6 table map to code 0
    function automatic logic [CODE_W-1:0] keymap_code(input layer_t lyr,
                                                      input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col);
        logic [CODE_W-1:0] code;
        code = '0;
        if (int'(lyr) < KM_LAYERS && int'(row) < KM_ROWS && int'(col) < KM_COLS)
        begin
            code = KEYMAP[lyr][row[1:0]][col[2:0]];
        end
        return code;
    endfunction

    function automatic logic is_special(input logic [CODE_W-1:0] code);
        return (code == CODE_ALT) || (code == CODE_GUI) || (code == CODE_LYR) ||
               (code == CODE_STAR) || (code == CODE_X);
    endfunction

    function automatic logic key_down(input logic [MASK_W-1:0] mask, input int pos);
        return |(mask & (MASK_W'(1) << pos));
    endfunction

endpackage

// File: rtl/lkms_front.sv
// Front end: takes scan words, resolves chord, layer and ALT keys, queues walk commands.
module lkms_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lkms_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output lkms_pkg::cmd_t                q_cmd
);

    logic gui_reg, gui_next;
    logic alt_reg, alt_next;
    logic l2_reg, l2_next;
    logic l1_on;

    logic [lkms_pkg::TIME_W-1:0] now;
    logic [lkms_pkg::MASK_W-1:0] mask;
    logic                        key_a, key_b, key_c;
    logic                        accept;
    lkms_pkg::evt_t              gui_evt, alt_evt;
    lkms_pkg::layer_t            layer;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && s_tuser[0];

    assign now   = s_tdata[lkms_pkg::TIME_W-1:0];
    assign mask  = s_tdata[lkms_pkg::TIME_W+lkms_pkg::MASK_W-1:lkms_pkg::TIME_W];
    assign key_a = lkms_pkg::key_down(mask, lkms_pkg::CHORD_A_POS);
    assign key_b = lkms_pkg::key_down(mask, lkms_pkg::CHORD_B_POS);
    assign key_c = lkms_pkg::key_down(mask, lkms_pkg::ALT_POS);

    always_comb
    begin
        gui_evt = lkms_pkg::EVT_NONE;
        alt_evt = lkms_pkg::EVT_NONE;

        if (key_a && key_b)
        begin
            if (!gui_reg)
            begin
                gui_evt = lkms_pkg::EVT_PRESS;
            end
            gui_next = 1'b1;
        end
        else
        begin
            if (gui_reg)
            begin
                gui_evt = lkms_pkg::EVT_RELEASE;
            end
            gui_next = 1'b0;
        end

        l1_on = key_a;

        if (!gui_next && key_b)
        begin
            l2_next = 1'b1;
        end
        else if (!key_b)
        begin
            l2_next = 1'b0;
        end
        else
        begin
            l2_next = l2_reg;
        end

        if (key_c && !l1_on && !l2_next)
        begin
            if (!alt_reg)
            begin
                alt_evt = lkms_pkg::EVT_PRESS;
            end
            alt_next = 1'b1;
        end
        else
        begin
            if (!key_c && alt_reg)
            begin
                alt_evt = lkms_pkg::EVT_RELEASE;
            end
            alt_next = 1'b0;
        end

        if (l1_on && !l2_next)
        begin
            layer = lkms_pkg::LYR_ONE;
        end
        else if (!l1_on && l2_next)
        begin
            layer = lkms_pkg::LYR_TWO;
        end
        else
        begin
            layer = lkms_pkg::LYR_BASE;
        end
    end

    always_comb
    begin
        q_cmd.now     = now;
        q_cmd.mask    = mask;
        q_cmd.layer   = layer;
        q_cmd.both    = l1_on && l2_next;
        q_cmd.gui_evt = gui_evt;
        q_cmd.alt_evt = alt_evt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gui_reg <= 1'b0;
            alt_reg <= 1'b0;
            l2_reg  <= 1'b0;
        end
        else if (q_push)
        begin
            gui_reg <= gui_next;
            alt_reg <= alt_next;
            l2_reg  <= l2_next;
        end
    end

endmodule

// File: rtl/lkms_queue.sv
// Short command queue between the front end and the walker.
module lkms_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lkms_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output lkms_pkg::cmd_t pop_cmd,
    output logic           empty
);

    lkms_pkg::cmd_t                ent_reg [lkms_pkg::QDEPTH];
    logic [lkms_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lkms_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lkms_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    assign full    = (cnt_reg == lkms_pkg::QCNT_W'(lkms_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == lkms_pkg::QPTR_W'(lkms_pkg::QDEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == lkms_pkg::QPTR_W'(lkms_pkg::QDEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/lkms_back.sv
// Back end: emits GUI/ALT words, walks key positions against the tap time table, drives output.
module lkms_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [lkms_pkg::DEB_W-1:0]  cfg_data,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  lkms_pkg::cmd_t              q_cmd,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lkms_pkg::CODE_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GUI   = 6'b000010,
        S_ALT   = 6'b000100,
        S_READ  = 6'b001000,
        S_EVAL  = 6'b010000,
        S_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [lkms_pkg::DEB_W-1:0]  deb_reg;
    lkms_pkg::cmd_t              cmd_reg;
    logic [lkms_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [lkms_pkg::COL_W-1:0]  col_reg, col_next;

    logic [lkms_pkg::TIME_W-1:0] tbl_mem [lkms_pkg::TBL_DEPTH];
    logic [lkms_pkg::TBL_DEPTH-1:0] tvld_reg;
    logic [lkms_pkg::TIME_W-1:0] rdata_reg;
    logic                        rvld_reg;
    logic [lkms_pkg::CODE_W-1:0] code_reg;
    logic                        press_reg;

    logic                        pend_valid_reg;
    logic [lkms_pkg::CODE_W-1:0] pend_code_reg;
    lkms_pkg::action_t           pend_act_reg;

    logic                        m_valid_reg;
    logic [lkms_pkg::CODE_W-1:0] m_code_reg;
    lkms_pkg::action_t           m_act_reg;
    logic                        m_last_reg;

    logic [lkms_pkg::CODE_W-1:0] code_c;
    logic [lkms_pkg::POS_W-1:0]  pos_c;
    logic [lkms_pkg::TIME_W-1:0] stamp;
    logic [lkms_pkg::TIME_W-1:0] delta;
    logic [lkms_pkg::TIME_W-1:0] deb_ext;
    logic                        too_soon, stale, last_pos;

    logic                        ev_req, ev_go, can_emit, out_free;
    logic [lkms_pkg::CODE_W-1:0] ev_code;
    lkms_pkg::action_t           ev_act;
    logic                        flush_out, out_load, rd_en;
    logic                        tbl_we;
    logic [lkms_pkg::TIME_W-1:0] tbl_wdata;

    assign code_c   = lkms_pkg::keymap_code(cmd_reg.layer, row_reg, col_reg);
    assign pos_c    = lkms_pkg::POS_W'(row_reg) * lkms_pkg::POS_W'(lkms_pkg::COLS)
                    + lkms_pkg::POS_W'(col_reg);
    assign stamp    = rvld_reg ? rdata_reg : '0;
    assign delta    = cmd_reg.now - stamp;
    assign deb_ext  = lkms_pkg::TIME_W'(deb_reg);
    assign too_soon = delta < deb_ext;
    assign stale    = delta > deb_ext;
    assign last_pos = (row_reg == lkms_pkg::ROW_W'(lkms_pkg::ROWS - 1)) &&
                      (col_reg == lkms_pkg::COL_W'(lkms_pkg::COLS - 1));

    assign out_free = !m_valid_reg || m_tready;
    assign can_emit = !pend_valid_reg || out_free;
    assign ev_go    = !ev_req || can_emit;
    assign out_load = (ev_req && ev_go && pend_valid_reg) || flush_out;

    // event wanted by the current step
    always_comb
    begin
        ev_req  = 1'b0;
        ev_code = code_reg;
        ev_act  = lkms_pkg::ACT_TAP;
        unique case (state_reg)
            S_GUI:
            begin
                ev_req  = (cmd_reg.gui_evt != lkms_pkg::EVT_NONE);
                ev_code = lkms_pkg::CODE_GUI;
                ev_act  = (cmd_reg.gui_evt == lkms_pkg::EVT_PRESS) ?
                          lkms_pkg::ACT_PRESS : lkms_pkg::ACT_RELEASE;
            end
            S_ALT:
            begin
                ev_req  = (cmd_reg.alt_evt != lkms_pkg::EVT_NONE);
                ev_code = lkms_pkg::CODE_ALT;
                ev_act  = (cmd_reg.alt_evt == lkms_pkg::EVT_PRESS) ?
                          lkms_pkg::ACT_PRESS : lkms_pkg::ACT_RELEASE;
            end
            S_EVAL:
            begin
                if (cmd_reg.both)
                begin
                    ev_req = press_reg;
                end
                else
                begin
                    ev_req = press_reg && !too_soon && !lkms_pkg::is_special(code_reg);
                end
            end
            S_IDLE, S_READ, S_FLUSH:
            begin
                ev_req = 1'b0;
            end
            default:
            begin
                ev_req = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        flush_out  = 1'b0;
        tbl_we     = 1'b0;
        tbl_wdata  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_GUI;
                end
            end
            S_GUI:
            begin
                if (ev_go)
                begin
                    state_next = S_ALT;
                end
            end
            S_ALT:
            begin
                if (ev_go)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (ev_go)
                begin
                    if (ev_req)
                    begin
                        tbl_we    = 1'b1;
                        tbl_wdata = cmd_reg.now;
                    end
                    else if (!cmd_reg.both && !too_soon && stale)
                    begin
                        tbl_we = 1'b1;
                    end
                    if (last_pos)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_READ;
                        if (col_reg == lkms_pkg::COL_W'(lkms_pkg::COLS - 1))
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    flush_out  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            deb_reg        <= lkms_pkg::DEB_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            tvld_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_valid)
            begin
                deb_reg <= cfg_data;
            end
            if (tbl_we)
            begin
                tvld_reg[code_reg] <= 1'b1;
            end
            if (flush_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (ev_req && ev_go)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (rd_en)
        begin
            code_reg  <= code_c;
            press_reg <= lkms_pkg::key_down(cmd_reg.mask, int'(pos_c));
            rdata_reg <= tbl_mem[code_c];
            rvld_reg  <= tvld_reg[code_c];
        end
        if (tbl_we)
        begin
            tbl_mem[code_reg] <= tbl_wdata;
        end
        if (ev_req && ev_go)
        begin
            pend_code_reg <= ev_code;
            pend_act_reg  <= ev_act;
        end
        if (out_load)
        begin
            m_code_reg <= pend_code_reg;
            m_act_reg  <= pend_act_reg;
            m_last_reg <= flush_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_code_reg;
    assign m_tuser  = m_act_reg;
    assign m_tlast  = m_last_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("walker state not one-hot");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("held word left over after scan");

    a_tap_not_special: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && ev_req && !cmd_reg.both) |->
            !lkms_pkg::is_special(code_reg))
        else $error("tap of a special code outside both layers");

    a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && !ev_go) |-> !tbl_we)
        else $error("time table written while stalled");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |=> !tbl_we)
        else $error("time table written on consecutive cycles");

endmodule

// File: rtl/layered_key_matrix_scanner.sv
// Top level of the layered key matrix scanner.
// Each accepted scan word with link up is walked step by step: the queue pop, the GUI and
// ALT steps, a read step and a write step per key position (the time table is a single-port
// memory), and the final flush; a stalled output adds its wait. Scans with link down are
// taken whenever the queue is not full and dropped. A two-entry queue lets up to two scans
// be taken while one is walked. The tap time table reads as zero after reset through
// per-code valid bits, so there is no clearing pass. cfg_data may be written at any time
// the block is idle.
module layered_key_matrix_scanner (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lkms_pkg::DEB_W-1:0]    cfg_data,   // debounce_ms
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lkms_pkg::S_DATA_W-1:0] s_tdata,    // now_ms[31:0], pressed_mask[55:32]
    input  logic [0:0]                    s_tuser,    // link_up[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lkms_pkg::CODE_W-1:0]   m_tdata,    // key_code[7:0]
    output logic [1:0]                    m_tuser,    // action[1:0]
    output logic                          m_tlast
);

    logic           q_push, q_full, q_pop, q_empty;
    lkms_pkg::cmd_t push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    lkms_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    lkms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    lkms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_cmd     (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: verif/lkms_event_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the layered key matrix scanner: predicts key events per scan and checks them.
module lkms_event_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lkms_pkg::DEB_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lkms_pkg::S_DATA_W-1:0] s_tdata,    // now_ms[31:0], pressed_mask[55:32]
    input  logic [0:0]                    s_tuser,    // link_up[0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lkms_pkg::CODE_W-1:0]   m_tdata,    // key_code[7:0]
    input  logic [1:0]                    m_tuser,    // action[1:0]
    input  logic                          m_tlast,
    output int                            pending,
    output int                            fail_count
);

    localparam logic [15:0] DEBOUNCE_AT_RESET = 16'd160;
    localparam int          MAX_REPORTS       = 10;

    localparam logic [7:0] LAYOUT [3][24] = '{
        '{8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'hB2,
          8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27,
          8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h82,
          8'h20, 8'h4C, 8'h58, 8'h2A, 8'h2A, 8'h2A},
        '{8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D,
          8'hD8, 8'hD9, 8'hDA, 8'hD7, 8'h2A, 8'h5C,
          8'h5B, 8'h5D, 8'hD2, 8'hD5, 8'hD3, 8'hD6,
          8'h20, 8'h4C, 8'h83, 8'h2A, 8'h2A, 8'h2A},
        '{8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
          8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD,
          8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A,
          8'h20, 8'h4C, 8'h58, 8'h2A, 8'h2A, 8'h2A}
    };

    typedef struct packed {
        logic [7:0]          code;
        lkms_pkg::action_t   act;
        logic                last;
    } key_evt_t;

    logic [15:0] debounce;
    logic        gui_on;
    logic        alt_on;
    logic        lyr1_on;
    logic        lyr2_on;
    logic [31:0] tap_stamp [256];
    key_evt_t    due_events [$];
    int          errs = 0;
    int          k;

    function automatic logic never_tapped(input logic [7:0] code);
        return code == lkms_pkg::CODE_ALT || code == lkms_pkg::CODE_GUI ||
               code == lkms_pkg::CODE_LYR || code == lkms_pkg::CODE_STAR ||
               code == lkms_pkg::CODE_X;
    endfunction

    function automatic key_evt_t evt(input logic [7:0] code, input lkms_pkg::action_t act);
        key_evt_t e;
        e.code = code;
        e.act  = act;
        e.last = 1'b0;
        return e;
    endfunction

    task automatic walk_scan(input logic [31:0] t, input logic [23:0] m);
        logic        a;
        logic        b;
        logic        c;
        logic        both;
        logic        skip;
        int          lyr;
        int          p;
        int          i;
        logic [7:0]  code;
        logic [31:0] d;
        key_evt_t    e;
        key_evt_t    evs [$];
        a = m[lkms_pkg::CHORD_A_POS];
        b = m[lkms_pkg::CHORD_B_POS];
        c = m[lkms_pkg::ALT_POS];

        if (a && b)
        begin
            if (!gui_on)
                evs.push_back(evt(lkms_pkg::CODE_GUI, lkms_pkg::ACT_PRESS));
            gui_on = 1'b1;
        end
        else
        begin
            if (gui_on)
                evs.push_back(evt(lkms_pkg::CODE_GUI, lkms_pkg::ACT_RELEASE));
            gui_on = 1'b0;
        end

        lyr1_on = a;
        if (!gui_on && b)
            lyr2_on = 1'b1;
        else if (!b)
            lyr2_on = 1'b0;

        if (c && !lyr1_on && !lyr2_on)
        begin
            if (!alt_on)
                evs.push_back(evt(lkms_pkg::CODE_ALT, lkms_pkg::ACT_PRESS));
            alt_on = 1'b1;
        end
        else
        begin
            if (!c && alt_on)
                evs.push_back(evt(lkms_pkg::CODE_ALT, lkms_pkg::ACT_RELEASE));
            alt_on = 1'b0;
        end

        both = lyr1_on && lyr2_on;
        lyr  = (lyr1_on && !lyr2_on) ? 1 : ((!lyr1_on && lyr2_on) ? 2 : 0);

        for (p = 0; p < 24; p++)
        begin
            code = LAYOUT[lyr][p];
            skip = 1'b0;
            // both layers on: no debounce, no stale clear, specials tapped too
            if (!both)
            begin
                d = t - tap_stamp[code];
                if (d < {16'd0, debounce})
                    skip = 1'b1;
                else
                begin
                    if (d > {16'd0, debounce})
                        tap_stamp[code] = '0;
                    if (never_tapped(code))
                        skip = 1'b1;
                end
            end
            if (!skip && m[p])
            begin
                evs.push_back(evt(code, lkms_pkg::ACT_TAP));
                tap_stamp[code] = t;
            end
        end

        for (i = 0; i < evs.size(); i++)
        begin
            e = evs[i];
            e.last = (i == evs.size() - 1);
            due_events.push_back(e);
        end
    endtask

    task automatic check_event(input logic [7:0] code, input logic [1:0] act, input logic last);
        key_evt_t want;
        if (due_events.size() == 0)
        begin
            errs++;
            if (errs <= MAX_REPORTS)
                $display("unexpected key word: code %h action %0d last %b", code, act, last);
        end
        else
        begin
            want = due_events.pop_front();
            if (want.code !== code || want.act !== act || want.last !== last)
            begin
                errs++;
                if (errs <= MAX_REPORTS)
                    $display("key word mismatch: expected code %h action %0d last %b, %s",
                             want.code, want.act, want.last,
                             $sformatf("got code %h action %0d last %b", code, act, last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce = DEBOUNCE_AT_RESET;
            gui_on   = 1'b0;
            alt_on   = 1'b0;
            lyr1_on  = 1'b0;
            lyr2_on  = 1'b0;
            for (k = 0; k < 256; k++)
                tap_stamp[k] = '0;
            due_events.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                debounce = cfg_data;
            if (s_tvalid && s_tready && s_tuser[0])
                walk_scan(s_tdata[31:0], s_tdata[55:32]);
            if (m_tvalid && m_tready)
                check_event(m_tdata, m_tuser, m_tlast);
            pending    <= due_events.size();
            fail_count <= errs;
        end
    end

endmodule

// File: verif/layered_key_matrix_scanner_tb.sv
`timescale 1ns / 100ps
// Testbench top for the layered key matrix scanner: clock, reset, stimulus and verdict.
module layered_key_matrix_scanner_tb;

    localparam int          SETTLE_CYCLES = 250;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          PHASE_SCANS   = 73;
    localparam logic [23:0] KEY_A   = 24'(1) << lkms_pkg::CHORD_A_POS;
    localparam logic [23:0] KEY_B   = 24'(1) << lkms_pkg::CHORD_B_POS;
    localparam logic [23:0] KEY_ALT = 24'(1) << lkms_pkg::ALT_POS;
    localparam logic [23:0] PLAIN   = 24'hFFFFFF & ~(KEY_A | KEY_B | KEY_ALT);

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lkms_pkg::DEB_W-1:0]    cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [lkms_pkg::S_DATA_W-1:0] s_tdata;    // now_ms[31:0], pressed_mask[55:32]
    logic [0:0]                    s_tuser;    // link_up[0]
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lkms_pkg::CODE_W-1:0]   m_tdata;    // key_code[7:0]
    logic [1:0]                    m_tuser;    // action[1:0]
    logic                          m_tlast;

    int          pending;
    int          fail_count;
    int          stuck_cycles = 0;
    logic        idling = 1'b1;
    logic [31:0] clock_ms;

    layered_key_matrix_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lkms_event_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= !idling || ($urandom_range(0, 99) >= 19);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_scan(input logic link, input logic [31:0] t, input logic [23:0] m);
        while (idling && $urandom_range(0, 99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {m, t};
        s_tuser  <= link;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // no new scans, all events in, then time for result-less scans still in the pipe
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_scans(input logic [15:0] deb, input int count);
        int          sent;
        logic [23:0] m;
        logic        link;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 7))
                0:       clock_ms = $urandom();
                1:       clock_ms = clock_ms + 32'(deb);
                2, 3:    clock_ms = clock_ms + $urandom_range(0, deb);
                default: clock_ms = clock_ms + $urandom_range(0, 2 * deb + 8);
            endcase
            case ($urandom_range(0, 9))
                0:       m = 24'($urandom());
                1:       m = '0;
                default:
                begin
                    m = 24'($urandom() & $urandom() & $urandom());
                    m[lkms_pkg::CHORD_A_POS] = ($urandom_range(0, 2) == 0);
                    m[lkms_pkg::CHORD_B_POS] = ($urandom_range(0, 2) == 0);
                    m[lkms_pkg::ALT_POS]     = ($urandom_range(0, 2) == 0);
                end
            endcase
            link = ($urandom_range(0, 9) != 0);
            send_scan(link, clock_ms, m);
            sent++;
        end
    endtask

    initial
    begin
        logic [15:0] deb;
        int          ph;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        clock_ms  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_scan(1'b0, 32'd0, 24'hFFFFFF);
        send_scan(1'b1, 32'd5, 24'hFFFFFF);
        send_scan(1'b1, 32'd1000, 24'h000000);
        send_scan(1'b1, 32'd1000, PLAIN);
        send_scan(1'b1, 32'd1100, PLAIN);
        send_scan(1'b1, 32'd1160, PLAIN);
        send_scan(1'b1, 32'd2000, KEY_ALT);
        send_scan(1'b1, 32'd2001, KEY_ALT);
        send_scan(1'b1, 32'd2002, KEY_ALT | KEY_A);
        send_scan(1'b1, 32'd2003, KEY_ALT);
        send_scan(1'b1, 32'd2004, 24'h000000);
        send_scan(1'b1, 32'd3000, KEY_B | 24'h000FFF);
        send_scan(1'b1, 32'd3001, KEY_A | KEY_B | KEY_ALT | 24'h0F0FFF);
        send_scan(1'b1, 32'd3002, KEY_A | KEY_B | KEY_ALT | 24'h0F0FFF);
        send_scan(1'b1, 32'd3003, KEY_B | 24'h000FFF);
        send_scan(1'b1, 32'd3500, KEY_A | 24'h03FFFF);
        send_scan(1'b1, 32'hFFFF_FFF0, 24'h01FFFF);
        send_scan(1'b1, 32'h0000_0010, 24'h01FFFF);
        send_scan(1'b1, 32'h8000_0000, 24'hFFFFFF);
        send_scan(1'b1, 32'hFFFF_FFFF, 24'h000000);
        send_scan(1'b0, $urandom(), 24'($urandom()));
        clock_ms = 32'h8000_1000;

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       deb = 16'd0;
                1:       deb = 16'hFFFF;
                2:       deb = 16'($urandom_range(1, 65534));
                3:       deb = 16'd1;
                4:       deb = 16'($urandom_range(0, 400));
                default: deb = 16'd160;
            endcase
            settle();
            idling = (ph != 2);
            write_debounce(deb);
            random_scans(deb, PHASE_SCANS);
        end

        idling = 1'b1;
        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: layered_key_matrix_scanner.f
rtl/lkms_pkg.sv
rtl/lkms_front.sv
rtl/lkms_queue.sv
rtl/lkms_back.sv
rtl/layered_key_matrix_scanner.sv
verif/lkms_event_checker.sv
verif/layered_key_matrix_scanner_tb.sv
